// ===== src/palette_voxel_store_sampler_defines.svh =====
// Assertion macros for the palette voxel store and sampler; the controller uses them.
`ifndef PALETTE_VOXEL_STORE_SAMPLER_DEFINES_SVH
`define PALETTE_VOXEL_STORE_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PVS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvs: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PVS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvs: next-cycle check failed");

`endif

// ===== src/pvs_pkg.sv =====
// Package with the types, constants and helper functions of the voxel store and sampler.
`default_nettype none

package pvs_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_PALETTE  = 256;
    localparam int INDEX_WORDS  = 1024;

    localparam logic [31:0] FILE_MAGIC = 32'h0070_6C67;

    localparam int PAL_DEPTH = MAX_CHANNELS * MAX_PALETTE;
    localparam int IDX_DEPTH = MAX_CHANNELS * INDEX_WORDS;
    localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int IDX_AW    = (IDX_DEPTH > 1) ? $clog2(IDX_DEPTH) : 1;

    localparam int RANK_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RANKX_W = RANK_W + 1;
    localparam int LEN_W   = $clog2(MAX_PALETTE + 1);
    localparam int COUNT_W = 6;
    localparam int BITS_W  = 5;
    localparam int PER_W   = 6;
    localparam int SHIFT_W = 5;

    localparam int WC_BIG = (MAX_PALETTE > INDEX_WORDS) ? MAX_PALETTE : INDEX_WORDS;
    localparam int WC_W   = $clog2(((WC_BIG > 6) ? WC_BIG : 6) + 1);

    // Voxel totals are kept saturated; this width holds any total that fits in memory.
    localparam int TOT_W  = $clog2(INDEX_WORDS * 32 + 1) + 1;
    localparam logic [TOT_W-1:0] TOT_CAP = '1;
    localparam int RCP_K   = TOT_W;
    localparam int RCP_ONE = 2 ** RCP_K;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } pvs_op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TAKEN      = 3'd1,
        ST_COMPLETE   = 3'd2,
        ST_BAD_MAGIC  = 3'd3,
        ST_CAPACITY   = 3'd4,
        ST_ABSENT     = 3'd5,
        ST_OUTSIDE    = 3'd6,
        ST_NOT_LOADED = 3'd7
    } pvs_status_t;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_RANGE   = 3'd1,
        PH_MASK    = 3'd2,
        PH_SIZES   = 3'd3,
        PH_PALETTE = 3'd4,
        PH_INDEX   = 3'd5,
        PH_DONE    = 3'd6,
        PH_FAIL    = 3'd7
    } pvs_phase_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_LOAD,
        CS_MISC,
        CS_CHECK,
        CS_MUL1,
        CS_MUL2,
        CS_DIV1,
        CS_DIV2,
        CS_IDX,
        CS_PAL,
        CS_RESP
    } pvs_state_t;

    typedef struct packed {
        pvs_op_t            operation;
        logic [31:0]        stream_word;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
        logic [4:0]         channel_bit;
    } pvs_req_t;

    typedef struct packed {
        logic [31:0] sample_value;
        pvs_status_t status;
    } pvs_rsp_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic misc;
        logic check;
        logic mul1;
        logic mul2;
        logic div1;
        logic div2;
        logic idx;
        logic pal;
    } pvs_cmd_t;

    typedef struct packed {
        pvs_op_t op;
        logic    early;
        logic    one_entry;
        logic    idx_ok;
    } pvs_stat_t;

    // Number of index bits for a palette of the given length.
    function automatic logic [BITS_W-1:0] bits_for(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]  v;
        logic [BITS_W-1:0] b;
        v = len - LEN_W'(1);
        b = '0;
        if (len > LEN_W'(1))
        begin
            for (int i = 0; i < LEN_W; i++)
            begin
                if (v[i])
                begin
                    b = BITS_W'(i + 1);
                end
            end
        end
        return b;
    endfunction

    // Voxels held in one 32-bit index word.
    function automatic logic [PER_W-1:0] per_of(input logic [BITS_W-1:0] b);
        logic [PER_W-1:0] p;
        case (b) inside
            5'd1:           p = 6'd32;
            5'd2:           p = 6'd16;
            5'd3:           p = 6'd10;
            5'd4:           p = 6'd8;
            5'd5:           p = 6'd6;
            5'd6:           p = 6'd5;
            [5'd7 : 5'd8]:  p = 6'd4;
            [5'd9 : 5'd10]: p = 6'd3;
            [5'd11 : 5'd16]: p = 6'd2;
            default:        p = 6'd0;
        endcase
        return p;
    endfunction

    // Scaled reciprocal of the voxels per word, rounded down.
    function automatic logic [TOT_W-1:0] rcp_of(input logic [BITS_W-1:0] b);
        logic [TOT_W-1:0] r;
        case (b) inside
            5'd1:           r = TOT_W'(RCP_ONE / 32);
            5'd2:           r = TOT_W'(RCP_ONE / 16);
            5'd3:           r = TOT_W'(RCP_ONE / 10);
            5'd4:           r = TOT_W'(RCP_ONE / 8);
            5'd5:           r = TOT_W'(RCP_ONE / 6);
            5'd6:           r = TOT_W'(RCP_ONE / 5);
            [5'd7 : 5'd8]:  r = TOT_W'(RCP_ONE / 4);
            [5'd9 : 5'd10]: r = TOT_W'(RCP_ONE / 3);
            [5'd11 : 5'd16]: r = TOT_W'(RCP_ONE / 2);
            default:        r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] popcount32(input logic [31:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 32; i++)
        begin
            n = n + COUNT_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [TOT_W-1:0] sat_tot(input logic [63:0] v);
        logic [TOT_W-1:0] r;
        if (v > 64'(TOT_CAP))
        begin
            r = TOT_CAP;
        end
        else
        begin
            r = v[TOT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pvs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/pvs_ctrl.sv =====
// Controller state machine that sequences loads, restarts, idle requests and samples.
`default_nettype none
`include "palette_voxel_store_sampler_defines.svh"

module pvs_ctrl import pvs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  pvs_stat_t stat,
    output pvs_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    pvs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    unique case (stat.op) inside
                        OP_LOAD:             state_next = CS_LOAD;
                        OP_SAMPLE:           state_next = CS_CHECK;
                        OP_RESTART, OP_NONE: state_next = CS_MISC;
                        default:             state_next = CS_MISC;
                    endcase
                end
            end
            CS_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = CS_RESP;
            end
            CS_MISC:
            begin
                cmd.misc   = 1'b1;
                state_next = CS_RESP;
            end
            CS_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.early)
                begin
                    state_next = CS_RESP;
                end
                else if (stat.one_entry)
                begin
                    state_next = CS_PAL;
                end
                else
                begin
                    state_next = CS_MUL1;
                end
            end
            CS_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = CS_MUL2;
            end
            CS_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = CS_DIV1;
            end
            CS_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = CS_DIV2;
            end
            CS_DIV2:
            begin
                cmd.div2   = 1'b1;
                state_next = CS_IDX;
            end
            CS_IDX:
            begin
                cmd.idx    = 1'b1;
                state_next = stat.idx_ok ? CS_PAL : CS_RESP;
            end
            CS_PAL:
            begin
                cmd.pal    = 1'b1;
                state_next = CS_RESP;
            end
            CS_RESP:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != CS_IDLE);
    assign done = (state_reg == CS_RESP);

    `PVS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PVS_ASSERT_NEXT(a_done_single, done, !done)
    `PVS_ASSERT_IMPL(a_done_busy, done, busy)
    `PVS_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.misc, cmd.check, cmd.mul1, cmd.mul2, cmd.div1, cmd.div2, cmd.idx, cmd.pal}))

endmodule

`default_nettype wire

// ===== src/pvs_dp.sv =====
// Datapath: file parser registers, palette and index memories, sample arithmetic.
`default_nettype none

module pvs_dp import pvs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  pvs_req_t  request,
    input  pvs_cmd_t  cmd,
    output pvs_stat_t stat,
    output pvs_rsp_t  result
);

    pvs_phase_t         phase_reg, phase_next;
    logic [WC_W-1:0]    wc_reg, wc_next, wc_inc;
    logic [31:0]        origin_reg [3];
    logic [31:0]        origin_next [3];
    logic [31:0]        extent_reg [3];
    logic [31:0]        extent_next [3];
    logic [31:0]        mask_reg, mask_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   plen_reg [MAX_CHANNELS];
    logic [LEN_W-1:0]   plen_next [MAX_CHANNELS];
    logic [LEN_W-1:0]   plen_view [MAX_CHANNELS];
    logic [RANK_W-1:0]  cur_reg, cur_next;
    pvs_status_t        fail_reg, fail_next;

    pvs_req_t           req_reg;
    pvs_rsp_t           result_reg, result_next;

    logic [TOT_W-1:0]   ex_t, ey_t, ez_t;
    logic [2*TOT_W-1:0] pxy_prod, tot_prod;
    logic [TOT_W-1:0]   pxy_reg, tot_reg;

    logic [RANKX_W-1:0] enter_start;
    logic               enter_found;
    logic [RANK_W-1:0]  enter_sel;

    logic [LEN_W-1:0]   cur_len;
    logic [BITS_W-1:0]  cur_bits;
    logic [PER_W-1:0]   cur_per;
    logic [BITS_W-1:0]  sz_bits;
    logic [TOT_W-1:0]   sz_limit;

    logic [31:0]        rel [3];
    logic               chk_outside, chk_bit, chk_rank_big, chk_early;
    logic [COUNT_W-1:0] chk_rank_full;
    logic [RANK_W-1:0]  chk_rank;
    logic [LEN_W-1:0]   chk_len;
    logic [BITS_W-1:0]  chk_bits;
    pvs_status_t        chk_status;

    logic [TOT_W-1:0]   rx_reg, ry_reg, rz_reg, t1_reg, lin_reg, q0_reg, rcp_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic [PER_W-1:0]   per_reg;
    logic [SHIFT_W-1:0] shift_reg;

    logic [2*TOT_W-1:0] m1_prod, m2_prod, d1_prod;
    logic [TOT_W+PER_W-1:0] d2_prod;
    logic [TOT_W-1:0]   d2_r0, d2_q;
    logic [PER_W-1:0]   d2_r;
    logic [2*BITS_W-1:0] d2_shift;

    logic [31:0]        idx_word, idx_mask, idx_val;
    logic               idx_ok;

    logic               pal_we, pal_re, idx_we;
    logic [PAL_AW-1:0]  pal_waddr, pal_raddr;
    logic [IDX_AW-1:0]  idx_waddr, idx_raddr;
    logic [31:0]        pal_rdata, idx_rdata;

    // Saturated voxel total, recomputed over two registered multiplies.
    assign ex_t     = sat_tot(64'(extent_reg[0]));
    assign ey_t     = sat_tot(64'(extent_reg[1]));
    assign ez_t     = sat_tot(64'(extent_reg[2]));
    assign pxy_prod = ex_t * ey_t;
    assign tot_prod = pxy_reg * ez_t;

    assign wc_inc   = wc_reg + WC_W'(1);
    assign cur_len  = plen_reg[cur_reg];
    assign cur_bits = bits_for(cur_len);
    assign cur_per  = per_of(cur_bits);
    assign sz_bits  = bits_for(req_reg.stream_word[LEN_W-1:0]);
    assign sz_limit = TOT_W'(INDEX_WORDS * int'(per_of(sz_bits)));

    // Next section with a non-empty palette, at or after the start rank.
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            plen_view[i] = plen_reg[i];
        end
        if (phase_reg == PH_SIZES && 32'(wc_reg) < 32'(MAX_CHANNELS))
        begin
            plen_view[wc_reg[RANK_W-1:0]] = req_reg.stream_word[LEN_W-1:0];
        end
        enter_start = (phase_reg == PH_SIZES) ? '0 : (RANKX_W'(cur_reg) + RANKX_W'(1));
        enter_found = 1'b0;
        enter_sel   = '0;
        for (int i = MAX_CHANNELS - 1; i >= 0; i--)
        begin
            if (RANKX_W'(i) >= enter_start && COUNT_W'(i) < count_reg && plen_view[i] != '0)
            begin
                enter_found = 1'b1;
                enter_sel   = RANK_W'(i);
            end
        end
    end

    // Sample checks on the captured request.
    always_comb
    begin
        rel[0] = $unsigned(req_reg.sample_x) - origin_reg[0];
        rel[1] = $unsigned(req_reg.sample_y) - origin_reg[1];
        rel[2] = $unsigned(req_reg.sample_z) - origin_reg[2];
        chk_outside = (rel[0] >= extent_reg[0]) || (rel[1] >= extent_reg[1])
                   || (rel[2] >= extent_reg[2]);
        chk_bit       = mask_reg[req_reg.channel_bit];
        chk_rank_full = popcount32(mask_reg & ((32'd1 << req_reg.channel_bit) - 32'd1));
        chk_rank_big  = chk_rank_full >= COUNT_W'(MAX_CHANNELS);
        chk_rank      = chk_rank_full[RANK_W-1:0];
        chk_len       = plen_reg[chk_rank];
        chk_bits      = bits_for(chk_len);
        chk_early     = 1'b1;
        if (phase_reg != PH_DONE)
        begin
            chk_status = ST_NOT_LOADED;
        end
        else if (!chk_bit)
        begin
            chk_status = ST_ABSENT;
        end
        else if (chk_outside)
        begin
            chk_status = ST_OUTSIDE;
        end
        else if (chk_rank_big)
        begin
            chk_status = ST_ABSENT;
        end
        else
        begin
            chk_status = ST_OK;
            chk_early  = (chk_len == '0);
        end
    end

    // Quotient correction and index extraction.
    assign m1_prod  = ey_t * rz_reg;
    assign m2_prod  = ex_t * t1_reg;
    assign d1_prod  = lin_reg * rcp_reg;
    assign d2_prod  = q0_reg * per_reg;
    assign d2_r0    = lin_reg - d2_prod[TOT_W-1:0];
    always_comb
    begin
        if (d2_r0 >= TOT_W'(per_reg))
        begin
            d2_q = q0_reg + TOT_W'(1);
            d2_r = PER_W'(d2_r0 - TOT_W'(per_reg));
        end
        else
        begin
            d2_q = q0_reg;
            d2_r = PER_W'(d2_r0);
        end
    end
    assign d2_shift = BITS_W'(d2_r) * bits_reg;

    assign idx_word = idx_rdata >> shift_reg;
    assign idx_mask = (32'd1 << bits_reg) - 32'd1;
    assign idx_val  = idx_word & idx_mask;
    assign idx_ok   = (idx_val < 32'(len_reg)) && (idx_val < 32'(MAX_PALETTE));

    assign stat.op        = request.operation;
    assign stat.early     = chk_early;
    assign stat.one_entry = (chk_bits == '0);
    assign stat.idx_ok    = idx_ok;

    always_comb
    begin
        phase_next  = phase_reg;
        wc_next     = wc_reg;
        origin_next = origin_reg;
        extent_next = extent_reg;
        mask_next   = mask_reg;
        count_next  = count_reg;
        plen_next   = plen_reg;
        cur_next    = cur_reg;
        fail_next   = fail_reg;
        result_next = result_reg;
        pal_we      = 1'b0;
        pal_waddr   = PAL_AW'(32'(cur_reg) * MAX_PALETTE + 32'(wc_reg));
        idx_we      = 1'b0;
        idx_waddr   = IDX_AW'(32'(cur_reg) * INDEX_WORDS + 32'(wc_reg));
        pal_re      = 1'b0;
        pal_raddr   = PAL_AW'(32'(chk_rank) * MAX_PALETTE);
        idx_raddr   = IDX_AW'(32'(rank_reg) * INDEX_WORDS + 32'(d2_q));

        if (cmd.load)
        begin
            result_next.sample_value = '0;
            result_next.status       = ST_TAKEN;
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (req_reg.stream_word != FILE_MAGIC)
                    begin
                        phase_next         = PH_FAIL;
                        fail_next          = ST_BAD_MAGIC;
                        result_next.status = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next = PH_RANGE;
                        wc_next    = '0;
                    end
                end
                PH_RANGE:
                begin
                    if (wc_reg < WC_W'(3))
                    begin
                        origin_next[wc_reg[1:0]] = req_reg.stream_word;
                    end
                    else if (wc_reg < WC_W'(6))
                    begin
                        extent_next[2'(wc_reg - WC_W'(3))] = req_reg.stream_word;
                    end
                    if (wc_inc >= WC_W'(6))
                    begin
                        phase_next = PH_MASK;
                        wc_next    = '0;
                    end
                    else
                    begin
                        wc_next = wc_inc;
                    end
                end
                PH_MASK:
                begin
                    mask_next  = req_reg.stream_word;
                    count_next = popcount32(req_reg.stream_word);
                    if (count_next > COUNT_W'(MAX_CHANNELS))
                    begin
                        phase_next         = PH_FAIL;
                        fail_next          = ST_CAPACITY;
                        result_next.status = ST_CAPACITY;
                    end
                    else if (count_next == '0)
                    begin
                        phase_next         = PH_DONE;
                        result_next.status = ST_COMPLETE;
                    end
                    else
                    begin
                        phase_next = PH_SIZES;
                        wc_next    = '0;
                    end
                end
                PH_SIZES:
                begin
                    if (req_reg.stream_word > 32'(MAX_PALETTE)
                        || (sz_bits != '0 && tot_reg > sz_limit))
                    begin
                        phase_next         = PH_FAIL;
                        fail_next          = ST_CAPACITY;
                        result_next.status = ST_CAPACITY;
                    end
                    else
                    begin
                        if (32'(wc_reg) < 32'(MAX_CHANNELS))
                        begin
                            plen_next[wc_reg[RANK_W-1:0]] = req_reg.stream_word[LEN_W-1:0];
                        end
                        if (32'(wc_inc) >= 32'(count_reg))
                        begin
                            wc_next = '0;
                            if (enter_found)
                            begin
                                phase_next = PH_PALETTE;
                                cur_next   = enter_sel;
                            end
                            else
                            begin
                                phase_next         = PH_DONE;
                                result_next.status = ST_COMPLETE;
                            end
                        end
                        else
                        begin
                            wc_next = wc_inc;
                        end
                    end
                end
                PH_PALETTE:
                begin
                    pal_we = 1'b1;
                    if (32'(wc_inc) >= 32'(cur_len))
                    begin
                        wc_next = '0;
                        if (cur_bits != '0 && tot_reg != '0)
                        begin
                            phase_next = PH_INDEX;
                        end
                        else if (enter_found)
                        begin
                            cur_next = enter_sel;
                        end
                        else
                        begin
                            phase_next         = PH_DONE;
                            result_next.status = ST_COMPLETE;
                        end
                    end
                    else
                    begin
                        wc_next = wc_inc;
                    end
                end
                PH_INDEX:
                begin
                    idx_we = 1'b1;
                    if (32'(wc_inc) * 32'(cur_per) >= 32'(tot_reg))
                    begin
                        wc_next = '0;
                        if (enter_found)
                        begin
                            phase_next = PH_PALETTE;
                            cur_next   = enter_sel;
                        end
                        else
                        begin
                            phase_next         = PH_DONE;
                            result_next.status = ST_COMPLETE;
                        end
                    end
                    else
                    begin
                        wc_next = wc_inc;
                    end
                end
                PH_DONE:
                begin
                    result_next.status = ST_COMPLETE;
                end
                PH_FAIL:
                begin
                    result_next.status = fail_reg;
                end
                default:
                begin
                    result_next.status = fail_reg;
                end
            endcase
        end
        else if (cmd.misc)
        begin
            if (req_reg.operation == OP_RESTART)
            begin
                phase_next = PH_MAGIC;
                wc_next    = '0;
                mask_next  = '0;
                count_next = '0;
                cur_next   = '0;
                fail_next  = ST_OK;
                for (int i = 0; i < 3; i++)
                begin
                    origin_next[i] = '0;
                    extent_next[i] = '0;
                end
                for (int i = 0; i < MAX_CHANNELS; i++)
                begin
                    plen_next[i] = '0;
                end
            end
            result_next.sample_value = '0;
            result_next.status       = ST_NOT_LOADED;
        end
        else if (cmd.check)
        begin
            if (chk_early)
            begin
                result_next.sample_value = '0;
                result_next.status       = chk_status;
            end
            else
            begin
                pal_re = (chk_bits == '0);
            end
        end
        else if (cmd.div2)
        begin
            idx_raddr = IDX_AW'(32'(rank_reg) * INDEX_WORDS + 32'(d2_q));
        end
        else if (cmd.idx)
        begin
            if (idx_ok)
            begin
                pal_re    = 1'b1;
                pal_raddr = PAL_AW'(32'(rank_reg) * MAX_PALETTE + idx_val);
            end
            else
            begin
                result_next.sample_value = '0;
                result_next.status       = ST_OK;
            end
        end
        else if (cmd.pal)
        begin
            result_next.sample_value = pal_rdata;
            result_next.status       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            wc_reg    <= '0;
            mask_reg  <= '0;
            count_reg <= '0;
            cur_reg   <= '0;
            fail_reg  <= ST_OK;
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                extent_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                plen_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            wc_reg     <= wc_next;
            mask_reg   <= mask_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            fail_reg   <= fail_next;
            origin_reg <= origin_next;
            extent_reg <= extent_next;
            plen_reg   <= plen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        pxy_reg    <= sat_tot(64'(pxy_prod));
        tot_reg    <= sat_tot(64'(tot_prod));
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.check)
        begin
            rx_reg   <= rel[0][TOT_W-1:0];
            ry_reg   <= rel[1][TOT_W-1:0];
            rz_reg   <= rel[2][TOT_W-1:0];
            rank_reg <= chk_rank;
            len_reg  <= chk_len;
            bits_reg <= chk_bits;
            per_reg  <= per_of(chk_bits);
            rcp_reg  <= rcp_of(chk_bits);
        end
        if (cmd.mul1)
        begin
            t1_reg <= ry_reg + m1_prod[TOT_W-1:0];
        end
        if (cmd.mul2)
        begin
            lin_reg <= rx_reg + m2_prod[TOT_W-1:0];
        end
        if (cmd.div1)
        begin
            q0_reg <= d1_prod[RCP_K +: TOT_W];
        end
        if (cmd.div2)
        begin
            shift_reg <= d2_shift[SHIFT_W-1:0];
        end
    end

    pvs_ram #(
        .WIDTH (32),
        .DEPTH (PAL_DEPTH)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (req_reg.stream_word),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    pvs_ram #(
        .WIDTH (32),
        .DEPTH (IDX_DEPTH)
    ) u_idx_ram (
        .clk   (clk),
        .we    (idx_we),
        .waddr (idx_waddr),
        .wdata (req_reg.stream_word),
        .re    (cmd.div2),
        .raddr (idx_raddr),
        .rdata (idx_rdata)
    );

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/palette_voxel_store_sampler.sv =====
// Top level of the palette-compressed voxel store and sampler.
// A load, restart or idle request runs through its load or misc state to the result strobe,
// and the next request is taken once idle again; a sample ends after check, index read or palette read.
// A full sample runs check, two multiplies, two divide steps, index read and palette read.
// Reset clears the parser and header registers; the memories are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module palette_voxel_store_sampler import pvs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  pvs_req_t request,
    output logic     busy,
    output logic     done,
    output pvs_rsp_t result
);

    // The controller steps through one request at a time. A sample first checks
    // load state, channel presence and the coordinate range, then forms the
    // linear voxel index with two multiplies, divides it by the voxels per word
    // through a reciprocal multiply and one correction step, reads the packed
    // index word and finally reads the palette entry.
    pvs_cmd_t  cmd;
    pvs_stat_t stat;

    pvs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the parser state, the header registers, both memories
    // and the sample arithmetic; the result register drives the result output.
    pvs_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

`default_nettype wire
